### hdl/rmq_pkg.sv
// Shared types, constants and the square-root step for the rotation-to-quaternion block.
// No dependencies; every other file but rmq_checker imports this package.
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;  // default fraction bits (Q2.14)
    localparam int NW            = 64;  // normalized length-squared word
    localparam int LW            = 32;  // length and scaled magnitude width
    localparam int DW            = 16;  // port field width

    typedef struct packed {
        logic valid;
        logic degenerate;
    } rmq_ctl_t;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [NW-1:0] res;
    } rmq_sqrt_t;

    // One digit of the bit-pair integer square root.
    function automatic rmq_sqrt_t rmq_sqrt_step(rmq_sqrt_t s, logic [NW-1:0] bit_v);
        rmq_sqrt_t     r;
        logic [NW-1:0] trial;
        trial = s.res + bit_v;
        if (s.rem >= trial)
        begin
            r.rem = s.rem - trial;
            r.res = (s.res >> 1) + bit_v;
        end
        else
        begin
            r.rem = s.rem;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

endpackage

### hdl/rmq_front.sv
// Front end: input saturation, four-way branch, squares and the length-squared sum.
// Depends on rmq_pkg.
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [15:0]     axis [9],
    output rmq_pkg::rmq_ctl_t      ctl_out,
    output logic [FRAC_BITS+2:0]   mag_out [4],
    output logic [3:0]             neg_out,
    output logic [rmq_pkg::NW-1:0] n_out
);
    import rmq_pkg::*;

    // wide enough for a raw 16-bit entry before the clamp and for the branch sums
    localparam int CW   = (FRAC_BITS + 4 > 17) ? FRAC_BITS + 4 : 17;
    localparam int MW   = FRAC_BITS + 3;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = 2 * MW + 2;
    localparam logic signed [CW-1:0] ONE = {{(CW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic signed [CW-1:0] v [9];
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] arg;
    logic signed [CW-1:0] c [4];

    logic signed [CW-1:0] c_reg [4];
    logic                 argpos_reg;
    logic                 v1_reg;

    logic [MW-1:0]        mag_next [4];
    logic [SQW-1:0]       sq_next [4];
    logic [SQW-1:0]       sq_reg [4];
    logic [MW-1:0]        mag2_reg [4];
    logic [3:0]           neg2_reg;
    logic                 argpos2_reg;
    logic                 v2_reg;

    logic [NW-1:0]        n_next;
    logic [NW-1:0]        n_reg;
    logic [MW-1:0]        mag3_reg [4];
    logic [3:0]           neg3_reg;
    logic                 deg3_reg;
    logic                 v3_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            v[i] = CW'(axis[i]);
            if (v[i] > ONE)
                v[i] = ONE;
            else if (v[i] < -ONE)
                v[i] = -ONE;
        end
        t = v[0] + v[4] + v[8];
        if (t > 0)
        begin
            arg  = t + ONE;
            c[0] = v[5] - v[7];
            c[1] = v[6] - v[2];
            c[2] = v[1] - v[3];
            c[3] = arg;
        end
        else if (v[0] > v[4] && v[0] > v[8])
        begin
            arg  = ONE + v[0] - v[4] - v[8];
            c[0] = arg;
            c[1] = v[3] + v[1];
            c[2] = v[6] + v[2];
            c[3] = v[5] - v[7];
        end
        else if (v[4] > v[8])
        begin
            arg  = ONE + v[4] - v[0] - v[8];
            c[0] = v[3] + v[1];
            c[1] = arg;
            c[2] = v[7] + v[5];
            c[3] = v[6] - v[2];
        end
        else
        begin
            arg  = ONE + v[8] - v[0] - v[4];
            c[0] = v[6] + v[2];
            c[1] = v[7] + v[5];
            c[2] = arg;
            c[3] = v[1] - v[3];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag_next[i] = c_reg[i][CW-1] ? MW'(-c_reg[i]) : MW'(c_reg[i]);
            sq_next[i]  = SQW'(mag_next[i]) * SQW'(mag_next[i]);
        end
        n_next = NW'(SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2])
                     + SUMW'(sq_reg[3]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg       <= c;
            argpos_reg  <= (arg > 0);
            sq_reg      <= sq_next;
            mag2_reg    <= mag_next;
            for (int i = 0; i < 4; i++)
                neg2_reg[i] <= c_reg[i][CW-1];
            argpos2_reg <= argpos_reg;
            n_reg       <= n_next;
            mag3_reg    <= mag2_reg;
            neg3_reg    <= neg2_reg;
            deg3_reg    <= !argpos2_reg || (n_next == '0);
        end
    end

    assign ctl_out.valid      = v3_reg;
    assign ctl_out.degenerate = deg3_reg;
    assign mag_out            = mag3_reg;
    assign neg_out            = neg3_reg;
    assign n_out              = n_reg;

endmodule

### hdl/rmq_norm.sv
// Normalizer: shifts length-squared left by bit pairs until bit 63 or 62 is set,
// then scales the component magnitudes by the matching power of two. Depends on rmq_pkg.
module rmq_norm #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  rmq_pkg::rmq_ctl_t      ctl_in,
    input  logic [rmq_pkg::NW-1:0] n_in,
    input  logic [FRAC_BITS+2:0]   mag_in [4],
    input  logic [3:0]             neg_in,
    output rmq_pkg::rmq_ctl_t      ctl_out,
    output logic [rmq_pkg::NW-1:0] n_out,
    output logic [rmq_pkg::LW-1:0] mg_out [4],
    output logic [3:0]             neg_out
);
    import rmq_pkg::*;

    localparam int MW = FRAC_BITS + 3;

    logic [NW-1:0] n1_next, n2_next;
    logic [1:0]    g1_next;
    logic [2:0]    g2_next;

    rmq_ctl_t      ctl1_reg, ctl2_reg, ctl3_reg;
    logic [NW-1:0] n1_reg, n2_reg, n3_reg;
    logic [1:0]    g1_reg;
    logic [4:0]    g2_reg;
    logic [MW-1:0] mag1_reg [4];
    logic [MW-1:0] mag2_reg [4];
    logic [LW-1:0] mg_next [4];
    logic [LW-1:0] mg3_reg [4];
    logic [3:0]    neg1_reg, neg2_reg, neg3_reg;

    always_comb
    begin
        n1_next = n_in;
        g1_next = '0;
        if (n1_next[NW-1 -: 32] == '0)
        begin
            n1_next    = n1_next << 32;
            g1_next[1] = 1'b1;
        end
        if (n1_next[NW-1 -: 16] == '0)
        begin
            n1_next    = n1_next << 16;
            g1_next[0] = 1'b1;
        end
        n2_next = n1_reg;
        g2_next = '0;
        if (n2_next[NW-1 -: 8] == '0)
        begin
            n2_next    = n2_next << 8;
            g2_next[2] = 1'b1;
        end
        if (n2_next[NW-1 -: 4] == '0)
        begin
            n2_next    = n2_next << 4;
            g2_next[1] = 1'b1;
        end
        if (n2_next[NW-1 -: 2] == '0)
        begin
            n2_next    = n2_next << 2;
            g2_next[0] = 1'b1;
        end
        for (int i = 0; i < 4; i++)
            mg_next[i] = LW'(NW'(mag2_reg[i]) << g2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= n1_next;
            g1_reg   <= g1_next;
            mag1_reg <= mag_in;
            neg1_reg <= neg_in;
            n2_reg   <= n2_next;
            g2_reg   <= {g1_reg, g2_next};
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            n3_reg   <= n2_reg;
            mg3_reg  <= mg_next;
            neg3_reg <= neg2_reg;
        end
    end

    assign ctl_out = ctl3_reg;
    assign n_out   = n3_reg;
    assign mg_out  = mg3_reg;
    assign neg_out = neg3_reg;

endmodule

### hdl/rmq_sqrt.sv
// Pipelined integer square root of the normalized length-squared, one result bit per stage.
// Carries the scaled magnitudes and signs alongside. Depends on rmq_pkg.
module rmq_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  rmq_pkg::rmq_ctl_t      ctl_in,
    input  logic [rmq_pkg::NW-1:0] n_in,
    input  logic [rmq_pkg::LW-1:0] mg_in [4],
    input  logic [3:0]             neg_in,
    output rmq_pkg::rmq_ctl_t      ctl_out,
    output logic [rmq_pkg::LW-1:0] len_out,
    output logic [rmq_pkg::LW-1:0] mg_out [4],
    output logic [3:0]             neg_out
);
    import rmq_pkg::*;

    rmq_sqrt_t     st_next [LW];
    rmq_sqrt_t     st_reg  [LW];
    rmq_ctl_t      ctl_reg [LW];
    logic [LW-1:0] mg_reg  [LW][4];
    logic [3:0]    neg_reg [LW];
    rmq_sqrt_t     cur;

    always_comb
    begin
        for (int k = 0; k < LW; k++)
        begin
            if (k == 0)
            begin
                cur.rem = n_in;
                cur.res = '0;
            end
            else
                cur = st_reg[k-1];
            st_next[k] = rmq_sqrt_step(cur, NW'(1) << (NW - 2 - 2 * k));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LW; k++)
                ctl_reg[k] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int k = 1; k < LW; k++)
                ctl_reg[k] <= ctl_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg     <= st_next;
            mg_reg[0]  <= mg_in;
            neg_reg[0] <= neg_in;
            for (int k = 1; k < LW; k++)
            begin
                mg_reg[k]  <= mg_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign ctl_out = ctl_reg[LW-1];
    assign len_out = st_reg[LW-1].res[LW-1:0];
    assign mg_out  = mg_reg[LW-1];
    assign neg_out = neg_reg[LW-1];

endmodule

### hdl/rmq_div.sv
// Four-lane pipelined restoring divider: rounds |c| * 2^FRAC_BITS / length,
// one quotient bit per stage. Depends on rmq_pkg.
module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  rmq_pkg::rmq_ctl_t      ctl_in,
    input  logic [rmq_pkg::LW-1:0] len_in,
    input  logic [rmq_pkg::LW-1:0] mg_in [4],
    input  logic [3:0]             neg_in,
    output rmq_pkg::rmq_ctl_t      ctl_out,
    output logic [FRAC_BITS:0]     q_out [4],
    output logic [3:0]             neg_out
);
    import rmq_pkg::*;

    localparam int QW   = FRAC_BITS + 1;
    localparam int NUMW = LW + 1 + FRAC_BITS;

    logic [NUMW-1:0] num [4];
    logic [LW:0]     trial;
    logic            ge;

    logic [LW-1:0]   r_next   [QW+1][4];
    logic [QW-1:0]   lo_next  [QW+1][4];
    logic [QW-1:0]   q_next   [QW+1][4];

    logic [LW-1:0]   r_reg    [QW+1][4];
    logic [QW-1:0]   lo_reg   [QW+1][4];
    logic [QW-1:0]   q_reg    [QW+1][4];
    logic [LW-1:0]   len_reg  [QW+1];
    logic [3:0]      neg_reg  [QW+1];
    rmq_ctl_t        ctl_reg  [QW+1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            num[i]        = NUMW'({mg_in[i], {FRAC_BITS{1'b0}}}) + NUMW'(len_in >> 1);
            r_next[0][i]  = num[i][NUMW-1:QW];
            lo_next[0][i] = num[i][QW-1:0];
            q_next[0][i]  = '0;
        end
        for (int k = 1; k <= QW; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                trial          = {r_reg[k-1][i], lo_reg[k-1][i][QW-k]};
                ge             = (trial >= {1'b0, len_reg[k-1]});
                r_next[k][i]   = ge ? LW'(trial - {1'b0, len_reg[k-1]}) : LW'(trial);
                lo_next[k][i]  = lo_reg[k-1][i];
                q_next[k][i]   = {q_reg[k-1][i][QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                ctl_reg[k] <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int k = 1; k <= QW; k++)
                ctl_reg[k] <= ctl_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= r_next;
            lo_reg     <= lo_next;
            q_reg      <= q_next;
            len_reg[0] <= len_in;
            neg_reg[0] <= neg_in;
            for (int k = 1; k <= QW; k++)
            begin
                len_reg[k] <= len_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign ctl_out = ctl_reg[QW];
    assign q_out   = q_reg[QW];
    assign neg_out = neg_reg[QW];

endmodule

### hdl/rotation_matrix_to_quaternion.sv
// Rotation basis to unit quaternion, fixed point, fully pipelined.
// Throughput: one transfer per cycle in each direction while out_ready is high.
// Pipeline: 3 front, 3 normalize, 32 square-root digits, FRAC_BITS + 2 divide stages,
//   1 output register.
// Reset: rst_n clears every valid bit at once; data registers are not reset.
// Depends on rmq_pkg, rmq_front, rmq_norm, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] x_axis_x,
    input  logic signed [15:0] x_axis_y,
    input  logic signed [15:0] x_axis_z,
    input  logic signed [15:0] y_axis_x,
    input  logic signed [15:0] y_axis_y,
    input  logic signed [15:0] y_axis_z,
    input  logic signed [15:0] z_axis_x,
    input  logic signed [15:0] z_axis_y,
    input  logic signed [15:0] z_axis_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic               degenerate
);
    import rmq_pkg::*;

    localparam int MW = FRAC_BITS + 3;
    localparam int QW = FRAC_BITS + 1;
    localparam int SW = (QW + 1 > DW + 1) ? QW + 1 : DW + 1;
    // identity scalar part, clipped to the port range for wide fractions
    localparam logic signed [DW-1:0] W_ONE =
        (FRAC_BITS >= DW - 1) ? 16'sh7fff : DW'(32'sd1 <<< FRAC_BITS);
    localparam logic signed [SW-1:0] SAT_HI = SW'(32'sd32767);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-32'sd32768);

    logic               en;
    logic signed [15:0] axis [9];

    rmq_ctl_t      fr_ctl, nm_ctl, sq_ctl, dv_ctl;
    logic [MW-1:0] fr_mag [4];
    logic [3:0]    fr_neg, nm_neg, sq_neg, dv_neg;
    logic [NW-1:0] fr_n, nm_n;
    logic [LW-1:0] nm_mg [4];
    logic [LW-1:0] sq_mg [4];
    logic [LW-1:0] sq_len;
    logic [QW-1:0] dv_q [4];

    logic signed [SW-1:0] sv [4];
    logic signed [DW-1:0] quat_next [4];
    logic signed [DW-1:0] quat_reg  [4];
    logic                 deg_reg;
    logic                 out_valid_reg;

    // Advance the whole pipe unless a finished result waits at the output with out_ready low.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign axis[0] = x_axis_x;
    assign axis[1] = x_axis_y;
    assign axis[2] = x_axis_z;
    assign axis[3] = y_axis_x;
    assign axis[4] = y_axis_y;
    assign axis[5] = y_axis_z;
    assign axis[6] = z_axis_x;
    assign axis[7] = z_axis_y;
    assign axis[8] = z_axis_z;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .axis     (axis),
        .ctl_out  (fr_ctl),
        .mag_out  (fr_mag),
        .neg_out  (fr_neg),
        .n_out    (fr_n)
    );

    rmq_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (fr_ctl),
        .n_in    (fr_n),
        .mag_in  (fr_mag),
        .neg_in  (fr_neg),
        .ctl_out (nm_ctl),
        .n_out   (nm_n),
        .mg_out  (nm_mg),
        .neg_out (nm_neg)
    );

    rmq_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (nm_ctl),
        .n_in    (nm_n),
        .mg_in   (nm_mg),
        .neg_in  (nm_neg),
        .ctl_out (sq_ctl),
        .len_out (sq_len),
        .mg_out  (sq_mg),
        .neg_out (sq_neg)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (sq_ctl),
        .len_in  (sq_len),
        .mg_in   (sq_mg),
        .neg_in  (sq_neg),
        .ctl_out (dv_ctl),
        .q_out   (dv_q),
        .neg_out (dv_neg)
    );

    // Restore the sign, clip to the port range, and substitute the identity
    // when the branch argument or the length collapsed.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sv[i] = SW'($signed({1'b0, dv_q[i]}));
            if (dv_neg[i])
                sv[i] = -sv[i];
            if (sv[i] > SAT_HI)
                sv[i] = SAT_HI;
            else if (sv[i] < SAT_LO)
                sv[i] = SAT_LO;
            quat_next[i] = DW'(sv[i]);
        end
        if (dv_ctl.degenerate)
        begin
            quat_next[0] = '0;
            quat_next[1] = '0;
            quat_next[2] = '0;
            quat_next[3] = W_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_ctl.valid;
    end

    // Hold the result while the consumer stalls.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_reg <= quat_next;
            deg_reg  <= dv_ctl.degenerate;
        end
    end

    assign out_valid  = out_valid_reg;
    assign quat_x     = quat_reg[0];
    assign quat_y     = quat_reg[1];
    assign quat_z     = quat_reg[2];
    assign quat_w     = quat_reg[3];
    assign degenerate = deg_reg;

endmodule

### hdl/rmq_checker.sv
// Port-level checks for the rotation-to-quaternion block, bound to its top level.
// Depends only on the top-level ports.
module rmq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [15:0] x_axis_x,
    input logic signed [15:0] x_axis_y,
    input logic signed [15:0] x_axis_z,
    input logic signed [15:0] y_axis_x,
    input logic signed [15:0] y_axis_y,
    input logic signed [15:0] y_axis_z,
    input logic signed [15:0] z_axis_x,
    input logic signed [15:0] z_axis_y,
    input logic signed [15:0] z_axis_z,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] quat_x,
    input logic signed [15:0] quat_y,
    input logic signed [15:0] quat_z,
    input logic signed [15:0] quat_w,
    input logic               degenerate
);

    a_deg_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> quat_x == 16'sd0 && quat_y == 16'sd0 && quat_z == 16'sd0)
        else $error("degenerate result without zero vector part");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_x) && $stable(quat_y)
            && $stable(quat_z) && $stable(quat_w) && $stable(degenerate))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge clk) !rst_n ##1 !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with free output");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(x_axis_x) && $stable(x_axis_y)
            && $stable(x_axis_z) && $stable(y_axis_x) && $stable(y_axis_y)
            && $stable(y_axis_z) && $stable(z_axis_x) && $stable(z_axis_y)
            && $stable(z_axis_z))
        else $error("waiting input changed before its transfer");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
